### rtl/core/tltm_pkg.sv
// Shared types, request codes and controller interface for the two-list top merge core.
`default_nettype none
package tltm_pkg;

   localparam int unsigned LIST_DEPTH_DEF = 20;
   localparam int unsigned OUT_LIMIT_DEF  = 20;
   localparam int unsigned DATA_W         = 288;
   localparam int unsigned KIND_W         = 2;

   localparam logic [KIND_W-1:0] REQ_LOAD_ONE = 2'd0;
   localparam logic [KIND_W-1:0] REQ_LOAD_TWO = 2'd1;
   localparam logic [KIND_W-1:0] REQ_MERGE    = 2'd2;

   typedef struct packed {
      logic [63:0]        name_high;
      logic [63:0]        name_low;
      logic signed [31:0] second_count;
      logic signed [31:0] level;
      logic signed [63:0] stamp;
      logic signed [31:0] key;
   } record_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_TAIL   = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_FETCH  = 6'b010000,
      ST_CAPT   = 6'b100000
   } state_type;

   typedef struct packed {
      logic load_one;
      logic load_two;
      logic merge_init;
      logic scan_init;
      logic scan_step;
      logic fetch;
      logic capture;
      logic push_hold;
      logic push_empty;
      logic set_final;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic found;
      logic limit;
      logic scan_last;
      logic hold_valid;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

### rtl/core/tltm_ctrl.sv
// Controller state machine sequencing loads, scans, fetches and result pushes.
`default_nettype none
module tltm_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic [tltm_pkg::KIND_W-1:0]   req_tuser,
   input  wire tltm_pkg::status_type          sts,
   output logic                               req_tready,
   output tltm_pkg::cmd_type                  cmd
);

   tltm_pkg::state_type state_ff;
   tltm_pkg::state_type state_in;
   logic                more;

   assign req_tready = (state_ff == tltm_pkg::ST_IDLE);
   assign more       = sts.found && !sts.limit;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         tltm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_tuser)
                  tltm_pkg::REQ_LOAD_ONE: cmd.load_one = 1'b1;
                  tltm_pkg::REQ_LOAD_TWO: cmd.load_two = 1'b1;
                  tltm_pkg::REQ_MERGE: begin
                     cmd.merge_init = 1'b1;
                     cmd.scan_init  = 1'b1;
                     state_in       = tltm_pkg::ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         tltm_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = tltm_pkg::ST_TAIL;
         end
         tltm_pkg::ST_TAIL: begin
            state_in = tltm_pkg::ST_DECIDE;
         end
         tltm_pkg::ST_DECIDE: begin
            if (more) begin
               if (!sts.hold_valid) begin
                  state_in = tltm_pkg::ST_FETCH;
               end else if (sts.rsp_free) begin
                  cmd.push_hold = 1'b1;
                  state_in      = tltm_pkg::ST_FETCH;
               end
            end else if (sts.rsp_free) begin
               cmd.push_hold  = sts.hold_valid;
               cmd.push_empty = !sts.hold_valid;
               cmd.set_final  = 1'b1;
               cmd.clear      = 1'b1;
               state_in       = tltm_pkg::ST_IDLE;
            end
         end
         tltm_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = tltm_pkg::ST_CAPT;
         end
         tltm_pkg::ST_CAPT: begin
            cmd.capture = 1'b1;
            if (sts.limit) begin
               state_in = tltm_pkg::ST_DECIDE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = tltm_pkg::ST_SCAN;
            end
         end
         default: state_in = tltm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= tltm_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

### rtl/core/tltm_dpath.sv
// Datapath: record memory, list counts, used marks, best-record scan and result register.
`default_nettype none
module tltm_dpath #(
   parameter int unsigned LIST_DEPTH = tltm_pkg::LIST_DEPTH_DEF,
   parameter int unsigned OUT_LIMIT  = tltm_pkg::OUT_LIMIT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tltm_pkg::cmd_type             cmd,
   input  wire logic [tltm_pkg::DATA_W-1:0]   req_tdata,
   input  wire logic                          rsp_tready,
   output tltm_pkg::status_type               sts,
   output logic                               rsp_tvalid,
   output logic [tltm_pkg::DATA_W-1:0]        rsp_tdata,
   output logic [0:0]                         rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int unsigned SLOTS  = 2 * LIST_DEPTH;
   localparam int unsigned SLOT_W = $clog2(SLOTS);
   localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int unsigned PICK_W = $clog2(OUT_LIMIT + 1);
   localparam int unsigned EXT_W  = SLOT_W + 1;

   tltm_pkg::record_type mem [SLOTS];
   tltm_pkg::record_type rd_data_ff;
   tltm_pkg::record_type hold_ff;
   tltm_pkg::record_type req_rec;
   tltm_pkg::record_type rsp_data_ff;

   logic [CNT_W-1:0]  cnt1_ff, cnt2_ff;
   logic [SLOTS-1:0]  used_ff;
   logic [SLOT_W-1:0] scan_ff;
   logic [SLOT_W-1:0] best_ff;
   logic [SLOT_W-1:0] cand_slot_ff;
   logic              cand_vld_ff;
   logic              cand_ok_ff;
   logic              found_ff;
   logic signed [31:0] best_key_ff;
   logic signed [63:0] best_time_ff;
   logic [PICK_W-1:0] pick_ff;
   logic              hold_valid_ff;
   logic              rsp_valid_ff;
   logic              rsp_user_ff;
   logic              rsp_last_ff;

   logic              we;
   logic [SLOT_W-1:0] wr_addr;
   logic [SLOT_W-1:0] rd_addr;
   logic [EXT_W-1:0]  scan_ext;
   logic              live;
   logic              qualify;
   logic              better;
   logic              take;
   logic              full1, full2;

   assign req_rec  = tltm_pkg::record_type'(req_tdata);
   assign full1    = (cnt1_ff >= CNT_W'(LIST_DEPTH));
   assign full2    = (cnt2_ff >= CNT_W'(LIST_DEPTH));
   assign we       = (cmd.load_one && !full1) || (cmd.load_two && !full2);
   assign wr_addr  = cmd.load_one ? SLOT_W'(cnt1_ff)
                                  : SLOT_W'(LIST_DEPTH) + SLOT_W'(cnt2_ff);
   assign rd_addr  = cmd.fetch ? best_ff : scan_ff;
   assign scan_ext = {1'b0, scan_ff};

   always_comb begin
      if (scan_ext < EXT_W'(LIST_DEPTH)) begin
         live = scan_ext < EXT_W'(cnt1_ff);
      end else begin
         live = (scan_ext - EXT_W'(LIST_DEPTH)) < EXT_W'(cnt2_ff);
      end
   end

   assign qualify = cand_vld_ff && cand_ok_ff && (rd_data_ff.key != 32'sd0)
                    && !rd_data_ff.key[31];
   assign better  = !found_ff || (rd_data_ff.key > best_key_ff)
                    || ((rd_data_ff.key == best_key_ff) && (rd_data_ff.stamp < best_time_ff));
   assign take    = qualify && better;

   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= req_rec;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt1_ff       <= '0;
         cnt2_ff       <= '0;
         used_ff       <= '0;
         scan_ff       <= '0;
         best_ff       <= '0;
         cand_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         pick_ff       <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load_one && !full1) begin
            cnt1_ff          <= cnt1_ff + CNT_W'(1);
            used_ff[wr_addr] <= 1'b0;
         end
         if (cmd.load_two && !full2) begin
            cnt2_ff          <= cnt2_ff + CNT_W'(1);
            used_ff[wr_addr] <= 1'b0;
         end
         if (cmd.merge_init) pick_ff <= '0;
         cand_vld_ff <= cmd.scan_step;
         if (cmd.scan_init) begin
            scan_ff  <= '0;
            found_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            scan_ff <= scan_ff + SLOT_W'(1);
         end
         if (take) begin
            best_ff  <= cand_slot_ff;
            found_ff <= 1'b1;
         end
         if (cmd.fetch) begin
            used_ff[best_ff] <= 1'b1;
            pick_ff          <= pick_ff + PICK_W'(1);
         end
         if (cmd.capture)        hold_valid_ff <= 1'b1;
         else if (cmd.push_hold) hold_valid_ff <= 1'b0;
         if (cmd.push_hold || cmd.push_empty) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)                 rsp_valid_ff <= 1'b0;
         if (cmd.clear) begin
            cnt1_ff       <= '0;
            cnt2_ff       <= '0;
            used_ff       <= '0;
            hold_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_slot_ff <= scan_ff;
      cand_ok_ff   <= live && !used_ff[scan_ff];
      if (take) begin
         best_key_ff  <= rd_data_ff.key;
         best_time_ff <= rd_data_ff.stamp;
      end
      if (cmd.capture) hold_ff <= rd_data_ff;
      if (cmd.push_hold || cmd.push_empty) begin
         rsp_data_ff <= cmd.push_empty ? tltm_pkg::record_type'('0) : hold_ff;
         rsp_user_ff <= !cmd.push_empty;
         rsp_last_ff <= cmd.set_final;
      end
   end

   assign sts.found      = found_ff;
   assign sts.limit      = (pick_ff == PICK_W'(OUT_LIMIT));
   assign sts.scan_last  = (scan_ff == SLOT_W'(SLOTS - 1));
   assign sts.hold_valid = hold_valid_ff;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;
   assign rsp_tlast    = rsp_last_ff;

endmodule
`default_nettype wire

### rtl/core/two_list_top_merge_core.sv
// Top level of the two-list top merge core: controller plus datapath.
//  channel  | dir | tdata (low bit up)                                 | tuser        | tlast
//  req_     | in  | key32 time64 level32 second_count32 name_lo64 hi64 | req_type[1:0]| -
//  rsp_     | out | key32 time64 level32 second_count32 name_lo64 hi64 | out_valid    | out_final
// A load request writes one record into its list; one may follow in every cycle.
// A merge request scans all 2*LIST_DEPTH slots, one a cycle, for each record it picks, then
// scans once more and finds no further record (no last scan once OUT_LIMIT records are picked);
// a result push waits while a result is pending and rsp_tready stays low.
// Reset clears list counts, used marks and control state; the record memory needs no clear.
// No request is taken while a merge runs; the last result may still wait in the output register.
`default_nettype none
module two_list_top_merge_core #(
   parameter int unsigned LIST_DEPTH = tltm_pkg::LIST_DEPTH_DEF,
   parameter int unsigned OUT_LIMIT  = tltm_pkg::OUT_LIMIT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // key, time, level, second_count, name_low, name_high
   input  wire logic [tltm_pkg::DATA_W-1:0]   req_tdata,
   // req_type
   input  wire logic [tltm_pkg::KIND_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // out_key, out_time, out_level, out_second_count, out_name_low, out_name_high
   output logic [tltm_pkg::DATA_W-1:0]        rsp_tdata,
   // out_valid
   output logic [0:0]                         rsp_tuser,
   output logic                               rsp_tlast
);

   tltm_pkg::cmd_type    cmd;
   tltm_pkg::status_type sts;

   tltm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   tltm_dpath #(
      .LIST_DEPTH (LIST_DEPTH),
      .OUT_LIMIT  (OUT_LIMIT)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_hold || cmd.push_empty) |-> sts.rsp_free)
      else $error("result pushed over a pending result");

   a_fetch_found: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |-> (sts.found && !sts.limit))
      else $error("fetch without a selected record");

   a_empty_only_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.push_empty |-> (!sts.hold_valid && cmd.set_final))
      else $error("empty marker while a record is held");

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.hold_valid)
      else $error("held record left over after merge");
`endif

endmodule
`default_nettype wire
